>>> hdl/bcvc_pkg.sv
// Shared types, constants and codes of the beep cadence and volume controller.
`default_nettype none

package bcvc_pkg;

    // Volume scale and derived widths
    localparam int VOL_LEVELS   = 5;
    localparam int STEP_W       = $clog2(VOL_LEVELS + 1);
    localparam int KFAC_W       = $clog2(7 * VOL_LEVELS + 1);
    localparam int NUM_W        = 16 + KFAC_W;

    // duty = floor(period * 7 * step / DUTY_DEN), done by reciprocal multiply
    localparam int DUTY_DEN     = 10 * VOL_LEVELS;
    localparam int RECIP_SHIFT  = NUM_W + 10;
    localparam longint unsigned RECIP_MUL_L = (64'd1 << RECIP_SHIFT) / DUTY_DEN;
    localparam int RECIP_W      = $clog2(RECIP_MUL_L + 1);
    localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'(RECIP_MUL_L);
    localparam int PROD_W       = NUM_W + RECIP_W;
    localparam int QUO_W        = PROD_W - RECIP_SHIFT;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(VOL_LEVELS / 2);
    localparam logic [STEP_W-1:0] STEP_MAX   = STEP_W'(VOL_LEVELS);

    // Configuration register reset values
    localparam logic [15:0] PWM_PERIOD_RESET = 16'd332;
    localparam logic [15:0] ON_TICKS_RESET   = 16'd1228;
    localparam logic [15:0] GAP_SHORT_RESET  = 16'd819;
    localparam logic [15:0] GAP_MEDIUM_RESET = 16'd2457;
    localparam logic [15:0] GAP_LONG_RESET   = 16'd4096;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PWM_PERIOD = 3'd0,
        CFG_ON_TICKS   = 3'd1,
        CFG_GAP_SHORT  = 3'd2,
        CFG_GAP_MEDIUM = 3'd3,
        CFG_GAP_LONG   = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CMD_BEEP   = 2'd0,
        CMD_VOL_DN = 2'd1,
        CMD_VOL_UP = 2'd2,
        CMD_MUTE   = 2'd3
    } t_cmd;

    // Alarm categories
    localparam logic [2:0] CAT_SILENT = 3'd0;
    localparam logic [2:0] CAT_LONG   = 3'd1;
    localparam logic [2:0] CAT_MEDIUM = 3'd2;
    localparam logic [2:0] CAT_SHORT  = 3'd3;
    localparam logic [2:0] CAT_CONT   = 3'd4;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_HELD  = 2'd1,
        PH_GAP   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_PROD  = 2'd1,
        ST_RECIP = 2'd2,
        ST_FIX   = 2'd3
    } t_ctl_state;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic prod_en;
        logic recip_en;
        logic fix_load;
    } t_dp_cmd;

endpackage

`default_nettype wire

>>> hdl/bcvc_in_if.sv
// Command channel: valid/ready handshake with the command item payload.
`default_nettype none

interface bcvc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [2:0] category;
    logic [15:0] now_time;

    modport source (output valid, output command, output category, output now_time,
                    input ready);
    modport sink   (input valid, input command, input category, input now_time,
                    output ready);
endinterface

`default_nettype wire

>>> hdl/bcvc_out_if.sv
// Result channel: valid/ready handshake with tone enable and duty compare.
`default_nettype none

interface bcvc_out_if;
    logic        valid;
    logic        ready;
    logic        tone_enable;
    logic [15:0] duty_compare;

    modport source (output valid, output tone_enable, output duty_compare, input ready);
    modport sink   (input valid, input tone_enable, input duty_compare, output ready);
endinterface

`default_nettype wire

>>> hdl/bcvc_dpath.sv
// Datapath: configuration registers, cadence state, volume, and duty arithmetic.
`default_nettype none

module bcvc_dpath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire bcvc_pkg::t_dp_cmd             i_cmd,
    input  wire logic [1:0]                    i_command,
    input  wire logic [2:0]                    i_category,
    input  wire logic [15:0]                   i_now_time,
    input  wire logic                          i_cfg_we,
    input  wire logic [bcvc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [15:0]                   i_cfg_data,
    output logic                               o_tone_enable,
    output logic [15:0]                        o_duty_compare
);

    // Configuration
    logic [15:0] r_pwm_period, r_on_ticks, r_gap_short, r_gap_medium, r_gap_long;

    // Cadence and volume state
    bcvc_pkg::t_phase             r_phase, n_phase, ph;
    logic [2:0]                   r_last_cat, n_last_cat;
    logic [15:0]                  r_ref_time, n_ref_time;
    logic [bcvc_pkg::STEP_W-1:0]  r_step, n_step;
    logic                         r_mute, n_mute;
    logic                         r_tone_on, n_tone_on;

    // Arithmetic pipeline
    logic [bcvc_pkg::KFAC_W-1:0]  r_kfac;
    logic [bcvc_pkg::NUM_W-1:0]   r_num;
    logic [bcvc_pkg::QUO_W-1:0]   r_quo;
    logic [bcvc_pkg::PROD_W-1:0]  w_prod;
    logic [bcvc_pkg::NUM_W-1:0]   w_back, w_rem;
    logic                         w_adj;

    // Output register
    logic        r_tone_out;
    logic [15:0] r_duty_out;

    logic [15:0] w_elapsed;
    logic        w_gap_done;

    assign w_elapsed  = i_now_time - r_ref_time;
    assign w_gap_done = (i_category == bcvc_pkg::CAT_SHORT  && w_elapsed >= r_gap_short)  ||
                        (i_category == bcvc_pkg::CAT_MEDIUM && w_elapsed >= r_gap_medium) ||
                        (i_category == bcvc_pkg::CAT_LONG   && w_elapsed >= r_gap_long);

    always_comb begin
        n_phase    = r_phase;
        n_last_cat = r_last_cat;
        n_ref_time = r_ref_time;
        n_step     = r_step;
        n_mute     = r_mute;
        n_tone_on  = r_tone_on;
        ph         = r_phase;
        unique case (bcvc_pkg::t_cmd'(i_command))
            bcvc_pkg::CMD_BEEP: begin
                if (r_mute) begin
                    n_tone_on = 1'b0;
                end else if (i_category == bcvc_pkg::CAT_SILENT) begin
                    n_tone_on = 1'b0;
                    n_phase   = bcvc_pkg::PH_START;
                end else begin
                    // restart the cadence on a new category
                    if (i_category != r_last_cat) begin
                        ph         = bcvc_pkg::PH_START;
                        n_ref_time = i_now_time;
                        n_last_cat = i_category;
                    end
                    n_phase = ph;
                    case (ph)
                        bcvc_pkg::PH_START: begin
                            n_tone_on  = 1'b1;
                            n_ref_time = i_now_time;
                            n_phase    = bcvc_pkg::PH_HELD;
                        end
                        bcvc_pkg::PH_HELD: begin
                            if (w_elapsed >= r_on_ticks) begin
                                if (i_category == bcvc_pkg::CAT_CONT) begin
                                    n_phase = bcvc_pkg::PH_START;
                                end else begin
                                    n_tone_on  = 1'b0;
                                    n_ref_time = i_now_time;
                                    n_phase    = bcvc_pkg::PH_GAP;
                                end
                            end
                        end
                        bcvc_pkg::PH_GAP: begin
                            if (w_gap_done) begin
                                n_phase = bcvc_pkg::PH_START;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            bcvc_pkg::CMD_VOL_DN: begin
                if (r_step != '0) begin
                    n_step = r_step - 1'b1;
                end
            end
            bcvc_pkg::CMD_VOL_UP: begin
                if (r_step < bcvc_pkg::STEP_MAX) begin
                    n_step = r_step + 1'b1;
                end
            end
            bcvc_pkg::CMD_MUTE: begin
                n_mute    = ~r_mute;
                n_tone_on = r_mute;
            end
            default: begin
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_period <= bcvc_pkg::PWM_PERIOD_RESET;
            r_on_ticks   <= bcvc_pkg::ON_TICKS_RESET;
            r_gap_short  <= bcvc_pkg::GAP_SHORT_RESET;
            r_gap_medium <= bcvc_pkg::GAP_MEDIUM_RESET;
            r_gap_long   <= bcvc_pkg::GAP_LONG_RESET;
        end else if (i_cfg_we) begin
            unique case (bcvc_pkg::t_cfg_idx'(i_cfg_idx))
                bcvc_pkg::CFG_PWM_PERIOD: r_pwm_period <= i_cfg_data;
                bcvc_pkg::CFG_ON_TICKS:   r_on_ticks   <= i_cfg_data;
                bcvc_pkg::CFG_GAP_SHORT:  r_gap_short  <= i_cfg_data;
                bcvc_pkg::CFG_GAP_MEDIUM: r_gap_medium <= i_cfg_data;
                bcvc_pkg::CFG_GAP_LONG:   r_gap_long   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Commit the item's state update on the accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= bcvc_pkg::PH_START;
            r_last_cat <= bcvc_pkg::CAT_SILENT;
            r_ref_time <= '0;
            r_step     <= bcvc_pkg::STEP_RESET;
            r_mute     <= 1'b0;
            r_tone_on  <= 1'b0;
        end else if (i_cmd.accept) begin
            r_phase    <= n_phase;
            r_last_cat <= n_last_cat;
            r_ref_time <= n_ref_time;
            r_step     <= n_step;
            r_mute     <= n_mute;
            r_tone_on  <= n_tone_on;
        end
    end

    // Duty arithmetic: product, reciprocal quotient estimate, one correction
    assign w_prod = bcvc_pkg::PROD_W'(r_num) * bcvc_pkg::PROD_W'(bcvc_pkg::RECIP_MUL);
    assign w_back = bcvc_pkg::NUM_W'(bcvc_pkg::NUM_W'(r_quo) *
                                     bcvc_pkg::NUM_W'(bcvc_pkg::DUTY_DEN));
    assign w_rem  = r_num - w_back;
    assign w_adj  = (w_rem >= bcvc_pkg::NUM_W'(bcvc_pkg::DUTY_DEN));

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kfac <= bcvc_pkg::KFAC_W'(bcvc_pkg::KFAC_W'(n_step) * bcvc_pkg::KFAC_W'(7));
        end
        if (i_cmd.prod_en) begin
            r_num <= bcvc_pkg::NUM_W'(bcvc_pkg::NUM_W'(r_pwm_period) *
                                      bcvc_pkg::NUM_W'(r_kfac));
        end
        if (i_cmd.recip_en) begin
            r_quo <= w_prod[bcvc_pkg::PROD_W-1:bcvc_pkg::RECIP_SHIFT];
        end
        if (i_cmd.fix_load) begin
            r_tone_out <= r_tone_on;
            r_duty_out <= 16'(r_quo + bcvc_pkg::QUO_W'(w_adj));
        end
    end

    assign o_tone_enable  = r_tone_out;
    assign o_duty_compare = r_duty_out;

endmodule

`default_nettype wire

>>> hdl/bcvc_ctrl.sv
// Controller: sequences accept, duty arithmetic steps and the result register.
`default_nettype none

module bcvc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output bcvc_pkg::t_dp_cmd      o_cmd
);

    bcvc_pkg::t_ctl_state r_state, n_state;
    logic                 r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bcvc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        n_out_valid    = r_out_valid && !i_out_ready;
        unique case (r_state)
            bcvc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = bcvc_pkg::ST_PROD;
                end
            end
            bcvc_pkg::ST_PROD: begin
                o_cmd.prod_en = 1'b1;
                n_state       = bcvc_pkg::ST_RECIP;
            end
            bcvc_pkg::ST_RECIP: begin
                o_cmd.recip_en = 1'b1;
                n_state        = bcvc_pkg::ST_FIX;
            end
            bcvc_pkg::ST_FIX: begin
                // hold until the result register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.fix_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = bcvc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bcvc_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.accept, o_cmd.prod_en, o_cmd.recip_en, o_cmd.fix_load}))
        else $error("more than one datapath command at once");

    a_accept_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> o_cmd.prod_en ##1 o_cmd.recip_en)
        else $error("arithmetic steps out of order after accept");

    a_fix_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bcvc_pkg::ST_FIX && r_out_valid && !i_out_ready)
        |=> (r_state == bcvc_pkg::ST_FIX && r_out_valid))
        else $error("result register overwritten while still held");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_cmd.fix_load))
        else $error("result valid raised without a result load");

endmodule

`default_nettype wire

>>> hdl/beep_cadence_volume_controller.sv
// Top level: beep cadence and volume controller with command and result channels.
// Each accepted item runs the product, reciprocal multiply and correction steps,
//   then loads the result register once the previous result has been claimed.
// A new item is accepted only in idle, after the three-step duty arithmetic of the
//   previous item has run in the controller's sequence.
// Reset: synchronous active-low; cadence, volume, mute and config return to defaults.
`default_nettype none

module beep_cadence_volume_controller (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    bcvc_in_if.sink                             i_req,
    bcvc_out_if.source                          o_rsp,
    input  wire logic                           i_cfg_we,
    input  wire logic [bcvc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [15:0]                    i_cfg_data
);

    bcvc_pkg::t_dp_cmd w_cmd;
    logic              w_in_ready;
    logic              w_out_valid;

    // Sequencer: takes a command beat in idle, then steps the duty pipeline
    // and loads the result register once the downstream side has room.
    bcvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (w_cmd)
    );

    // Cadence/volume state update happens on the accepted beat; the duty
    // compare is derived from the updated volume step afterwards.
    bcvc_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_command      (i_req.command),
        .i_category     (i_req.category),
        .i_now_time     (i_req.now_time),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_tone_enable  (o_rsp.tone_enable),
        .o_duty_compare (o_rsp.duty_compare)
    );

    assign i_req.ready = w_in_ready;
    assign o_rsp.valid = w_out_valid;

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the beep cadence and volume controller.
`timescale 1ns / 1ps

// Tracks cadence, volume and mute exactly as the controller should, and holds
// the tone/duty pairs still owed by the block in arrival order.
class tone_duty_board;
    typedef struct packed {
        logic        tone_enable;
        logic [15:0] duty_compare;
    } t_tone_duty;

    t_tone_duty       pending_tone_duty[$];
    logic [15:0]      cfg_reg [5];
    bcvc_pkg::t_phase phase;
    logic [2:0]       last_cat;
    logic [15:0]      ref_time;
    int               vol_step;
    bit               muted;
    bit               tone;
    int               errors;

    function new();
        cfg_reg[bcvc_pkg::CFG_PWM_PERIOD] = bcvc_pkg::PWM_PERIOD_RESET;
        cfg_reg[bcvc_pkg::CFG_ON_TICKS]   = bcvc_pkg::ON_TICKS_RESET;
        cfg_reg[bcvc_pkg::CFG_GAP_SHORT]  = bcvc_pkg::GAP_SHORT_RESET;
        cfg_reg[bcvc_pkg::CFG_GAP_MEDIUM] = bcvc_pkg::GAP_MEDIUM_RESET;
        cfg_reg[bcvc_pkg::CFG_GAP_LONG]   = bcvc_pkg::GAP_LONG_RESET;
        phase    = bcvc_pkg::PH_START;
        last_cat = bcvc_pkg::CAT_SILENT;
        ref_time = '0;
        vol_step = bcvc_pkg::VOL_LEVELS / 2;
        muted    = 1'b0;
        tone     = 1'b0;
        errors   = 0;
    endfunction

    // Advance the state by one accepted command beat and queue its result.
    function void note_command(bcvc_pkg::t_cmd cmd, logic [2:0] cat, logic [15:0] now);
        t_tone_duty  due;
        logic [15:0] elapsed;
        case (cmd)
            bcvc_pkg::CMD_BEEP: begin
                elapsed = now - ref_time;
                if (muted) begin
                    tone = 1'b0;
                end else if (cat == bcvc_pkg::CAT_SILENT) begin
                    tone  = 1'b0;
                    phase = bcvc_pkg::PH_START;
                end else begin
                    // a new category restarts the cadence within this beat
                    if (cat != last_cat) begin
                        phase    = bcvc_pkg::PH_START;
                        ref_time = now;
                        last_cat = cat;
                    end
                    case (phase)
                        bcvc_pkg::PH_START: begin
                            tone     = 1'b1;
                            ref_time = now;
                            phase    = bcvc_pkg::PH_HELD;
                        end
                        bcvc_pkg::PH_HELD: begin
                            if (elapsed >= cfg_reg[bcvc_pkg::CFG_ON_TICKS]) begin
                                if (cat == bcvc_pkg::CAT_CONT) begin
                                    phase = bcvc_pkg::PH_START;
                                end else begin
                                    tone     = 1'b0;
                                    ref_time = now;
                                    phase    = bcvc_pkg::PH_GAP;
                                end
                            end
                        end
                        bcvc_pkg::PH_GAP: begin
                            // categories above continuous have no gap length
                            if ((cat == bcvc_pkg::CAT_SHORT &&
                                 elapsed >= cfg_reg[bcvc_pkg::CFG_GAP_SHORT]) ||
                                (cat == bcvc_pkg::CAT_MEDIUM &&
                                 elapsed >= cfg_reg[bcvc_pkg::CFG_GAP_MEDIUM]) ||
                                (cat == bcvc_pkg::CAT_LONG &&
                                 elapsed >= cfg_reg[bcvc_pkg::CFG_GAP_LONG]))
                                phase = bcvc_pkg::PH_START;
                        end
                        default: ;
                    endcase
                end
            end
            bcvc_pkg::CMD_VOL_DN: if (vol_step > 0) vol_step--;
            bcvc_pkg::CMD_VOL_UP: if (vol_step < bcvc_pkg::VOL_LEVELS) vol_step++;
            default: begin
                muted = !muted;
                tone  = !muted;
            end
        endcase
        due.tone_enable  = tone;
        due.duty_compare = 16'((longint'(cfg_reg[bcvc_pkg::CFG_PWM_PERIOD]) * 7 * vol_step)
                               / (10 * bcvc_pkg::VOL_LEVELS));
        pending_tone_duty.push_back(due);
    endfunction

    // Compare one result beat against the oldest owed pair.
    function void check_result(logic tone_en, logic [15:0] duty);
        t_tone_duty want;
        if (pending_tone_duty.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: tone %0b duty %0d", tone_en, duty);
            return;
        end
        want = pending_tone_duty.pop_front();
        if (want.tone_enable !== tone_en || want.duty_compare !== duty) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: tone exp %0b got %0b, duty exp %0d got %0d",
                         want.tone_enable, tone_en, want.duty_compare, duty);
        end
    endfunction
endclass

module tb;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 8;     // margin for the block to settle
    localparam int SEG_ITEMS     = 104;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [bcvc_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [15:0]                    cfg_data;

    bcvc_in_if  req_if ();
    bcvc_out_if rsp_if ();

    tone_duty_board board = new();

    int send_idle_pct;    // chance of an idle cycle before each command beat
    int rsp_stall_pct;    // chance the receiver drops ready in a cycle
    int hold_request;     // long receiver hold asked for by the stimulus
    int hold_left;
    int cycles;

    beep_cadence_volume_controller uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Abort on a hung handshake.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver: drive ready at the falling edge; a hold request takes priority
    // over random stalls and keeps ready low for the whole stretch.
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
        end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
        end
    end

    // Sample result beats at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            board.check_result(rsp_if.tone_enable, rsp_if.duty_compare);
    end

    // Offer one command beat, idling first at random, and note it once taken.
    // Valid stays high afterwards; the next call or a drain changes it.
    task automatic send_command(bcvc_pkg::t_cmd cmd, logic [2:0] cat, logic [15:0] now);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.command  <= cmd;
        req_if.category <= cat;
        req_if.now_time <= now;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        board.note_command(cmd, cat, now);
    endtask

    // Drop valid and hold off until every owed result is back and the block
    // has had time to settle.
    task automatic drain_results();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (board.pending_tone_duty.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one configuration register; only called with the block idle.
    task automatic write_reg(bcvc_pkg::t_cfg_idx idx, logic [15:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        board.cfg_reg[idx] = val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int                  seg;
        int                  n;
        int                  r;
        int                  span;
        logic [15:0]         seg_val [5];
        logic [15:0]         clock_now;
        logic [2:0]          cur_cat;
        bcvc_pkg::t_cmd      cmd;
        bcvc_pkg::t_cfg_idx  bidx;

        // Hold every input at a known value from time zero.
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = bcvc_pkg::CFG_PWM_PERIOD;
        cfg_data        = '0;
        req_if.valid    = 1'b0;
        req_if.command  = bcvc_pkg::CMD_BEEP;
        req_if.category = bcvc_pkg::CAT_SILENT;
        req_if.now_time = '0;
        rsp_if.ready    = 1'b0;
        send_idle_pct   = 0;
        rsp_stall_pct   = 0;
        hold_request    = 0;
        hold_left       = 0;
        cycles          = 0;
        clock_now       = '0;
        cur_cat         = bcvc_pkg::CAT_LONG;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pass with reset configuration and no idling.
        send_command(bcvc_pkg::CMD_BEEP, bcvc_pkg::CAT_SILENT, 16'd0);
        // step 2 up to the top, then one more that must be ignored
        repeat (4) send_command(bcvc_pkg::CMD_VOL_UP, bcvc_pkg::CAT_SILENT, 16'hFFFF);
        // long category: start, one tick short of on time, gap, gap edge
        send_command(bcvc_pkg::CMD_BEEP, bcvc_pkg::CAT_LONG, 16'd0);
        send_command(bcvc_pkg::CMD_BEEP, bcvc_pkg::CAT_LONG, 16'd1227);
        send_command(bcvc_pkg::CMD_BEEP, bcvc_pkg::CAT_LONG, 16'd1228);
        send_command(bcvc_pkg::CMD_BEEP, bcvc_pkg::CAT_LONG, 16'd5323);
        send_command(bcvc_pkg::CMD_BEEP, bcvc_pkg::CAT_LONG, 16'd5324);
        // continuous tone; the second sample wraps the timer
        send_command(bcvc_pkg::CMD_BEEP, bcvc_pkg::CAT_CONT, 16'hFFFF);
        send_command(bcvc_pkg::CMD_BEEP, bcvc_pkg::CAT_CONT, 16'd1227);
        // category without a gap length: the gap never ends
        send_command(bcvc_pkg::CMD_BEEP, 3'd7, 16'h8000);
        send_command(bcvc_pkg::CMD_BEEP, 3'd7, 16'hFFFF);
        send_command(bcvc_pkg::CMD_BEEP, 3'd7, 16'h0000);
        // mute, update ignored while muted, volume to the floor and past it
        send_command(bcvc_pkg::CMD_MUTE, bcvc_pkg::CAT_SILENT, 16'd0);
        send_command(bcvc_pkg::CMD_BEEP, bcvc_pkg::CAT_MEDIUM, 16'h1234);
        repeat (6) send_command(bcvc_pkg::CMD_VOL_DN, 3'd7, 16'h5555);
        send_command(bcvc_pkg::CMD_MUTE, bcvc_pkg::CAT_SILENT, 16'hAAAA);
        send_command(bcvc_pkg::CMD_BEEP, bcvc_pkg::CAT_SHORT, 16'h00FF);
        send_command(bcvc_pkg::CMD_BEEP, 3'd5, 16'hFF00);
        send_command(bcvc_pkg::CMD_BEEP, 3'd6, 16'h7FFF);
        drain_results();

        // Random segments: each gets its own register setting and idle mix.
        for (seg = 0; seg < 8; seg++) begin
            case (seg)
                0: seg_val = '{bcvc_pkg::PWM_PERIOD_RESET, bcvc_pkg::ON_TICKS_RESET,
                               bcvc_pkg::GAP_SHORT_RESET, bcvc_pkg::GAP_MEDIUM_RESET,
                               bcvc_pkg::GAP_LONG_RESET};
                1: seg_val = '{16'($urandom), 16'd4, 16'd2, 16'd5, 16'd9};
                2: seg_val = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
                3: seg_val = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                4: seg_val = '{16'($urandom), 16'($urandom_range(0, 20)),
                               16'($urandom_range(0, 20)), 16'($urandom_range(0, 20)),
                               16'($urandom_range(0, 20))};
                5: seg_val = '{16'($urandom_range(0, 400)), 16'($urandom_range(0, 3000)),
                               16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)),
                               16'($urandom_range(0, 3000))};
                6: seg_val = '{16'hFFFF, 16'($urandom_range(0, 8)),
                               16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)),
                               16'($urandom_range(0, 12))};
                default: seg_val = '{16'($urandom), 16'($urandom), 16'($urandom),
                                     16'($urandom), 16'($urandom)};
            endcase
            for (n = 0; n < 5; n++) write_reg(bcvc_pkg::t_cfg_idx'(n), seg_val[n]);

            // Idle mix cycles through: none, sender, receiver, both.
            case (seg % 4)
                0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
                1: begin send_idle_pct = 65; rsp_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rsp_stall_pct = 65; end
                default: begin send_idle_pct = 36; rsp_stall_pct = 36; end
            endcase

            // Scale timer steps to the longest interval so phases advance.
            span = 0;
            for (n = 1; n < 5; n++) if (int'(seg_val[n]) > span) span = int'(seg_val[n]);

            for (n = 0; n < SEG_ITEMS; n++) begin
                // Back-pressure: stall the receiver long enough to fill the block.
                if ((seg == 0 && n == 50) || (seg == 2 && n == 40)) hold_request = 300;
                // Pause the sender until everything owed has come back.
                if (seg == 5 && n == 50) drain_results();

                // Mostly beep updates; unmute soon so the cadence keeps running.
                r = $urandom_range(0, 99);
                if (board.muted && $urandom_range(0, 3) == 0) cmd = bcvc_pkg::CMD_MUTE;
                else if (r < 80) cmd = bcvc_pkg::CMD_BEEP;
                else if (r < 88) cmd = bcvc_pkg::CMD_VOL_DN;
                else if (r < 96) cmd = bcvc_pkg::CMD_VOL_UP;
                else cmd = bcvc_pkg::CMD_MUTE;

                // Keep a category for a run of beats, then switch.
                if ($urandom_range(0, 99) < 10) begin
                    r = $urandom_range(0, 19);
                    if (r < 2) cur_cat = bcvc_pkg::CAT_SILENT;
                    else if (r == 2) cur_cat = 3'($urandom_range(5, 7));
                    else cur_cat = 3'($urandom_range(1, 4));
                end

                // Timer: land on an interval edge, jump anywhere, or creep forward.
                r = $urandom_range(0, 99);
                if (r < 12) begin
                    bidx      = bcvc_pkg::t_cfg_idx'($urandom_range(1, 4));
                    clock_now = board.ref_time + board.cfg_reg[bidx]
                                - 16'($urandom_range(0, 1));
                end else if (r < 20) begin
                    clock_now = 16'($urandom);
                end else begin
                    clock_now = clock_now + 16'($urandom_range(0, span / 3 + 1));
                end

                send_command(cmd, (cmd == bcvc_pkg::CMD_BEEP) ? cur_cat : 3'($urandom),
                             clock_now);
            end
            drain_results();
        end

        if (board.errors == 0 && board.pending_tone_duty.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

>>> beep_cadence_volume_controller.f
hdl/bcvc_pkg.sv
hdl/bcvc_in_if.sv
hdl/bcvc_out_if.sv
hdl/bcvc_dpath.sv
hdl/bcvc_ctrl.sv
hdl/beep_cadence_volume_controller.sv
tb/tb.sv
